// ===== design/imuv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuv_pkg
// Shared types and constants of the IMU interquartile outlier voter.
// ----------------------------------------------------------------------------
package imuv_pkg;

    localparam int NUM_IMUS   = 4;
    localparam int ACCEL_W    = 32;
    localparam int SCALE_W    = 16;
    localparam int MAX_IQR_W  = 31;
    localparam int LIMIT_W    = 16;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int UCNT_W     = 3;
    localparam int FENCE_W    = 51;   // fences in units of 1/512 LSB
    localparam int PROD_W     = 48;   // scale times clipped doubled IQR

    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IQR_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IQR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT = 2'd2;

    localparam logic [SCALE_W-1:0]   IQR_SCALE_RST = 16'd384;
    localparam logic [MAX_IQR_W-1:0] MAX_IQR_RST   = 31'd327680;
    localparam logic [LIMIT_W-1:0]   RUN_LIMIT_RST = 16'd1000;

    localparam logic [UCNT_W-1:0]    UCNT_MAX      = 3'd7;

    typedef logic signed [ACCEL_W-1:0] accel_t;
    typedef logic [NUM_IMUS-1:0]       imu_mask_t;

    // fences and replacement value for one sample set
    typedef struct packed {
        logic                       active;   // three or more reliable IMUs
        logic signed [FENCE_W-1:0]  lower;
        logic signed [FENCE_W-1:0]  upper;
        accel_t                     median;
    } fence_t;

    // per-item status handed from the tracker to the result register
    typedef struct packed {
        imu_mask_t outlier;
        imu_mask_t reliable;
        logic      failure;
    } status_t;

endpackage

// ===== design/imuv_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuv_stats
// Sort network over the reliable readings, quartiles, median, clipped IQR
// and Tukey fences.
// ----------------------------------------------------------------------------
module imuv_stats (
    input  imuv_pkg::accel_t                    accel [imuv_pkg::NUM_IMUS],
    input  imuv_pkg::imu_mask_t                 reliable,
    input  logic [imuv_pkg::SCALE_W-1:0]        iqr_scale,
    input  logic [imuv_pkg::MAX_IQR_W-1:0]      max_iqr,
    output imuv_pkg::fence_t                    fence
);

    localparam int KEY_W = imuv_pkg::ACCEL_W + 1;

    // key: unreliable readings sort above everything, value bits offset-binary
    logic [KEY_W-1:0] k0, k1, k2, k3;
    logic [KEY_W-1:0] a0, a1, a2, a3;
    logic [KEY_W-1:0] b0, b1, b2, b3;
    logic [KEY_W-1:0] c1, c2;
    logic signed [imuv_pkg::ACCEL_W-1:0] s0, s1, s2, s3;
    logic signed [imuv_pkg::ACCEL_W:0]   q1x2, q3x2, m12, s23;
    logic signed [imuv_pkg::ACCEL_W+1:0] iqr2;
    logic [imuv_pkg::ACCEL_W-1:0]        clip2, iqr_c;
    logic [imuv_pkg::PROD_W-1:0]         off;
    logic                                four;

    function automatic logic [KEY_W-1:0] make_key(input logic rel, input logic [31:0] x);
        make_key = {~rel, ~x[31], x[30:0]};
    endfunction

    function automatic logic signed [31:0] key_value(input logic [KEY_W-1:0] k);
        key_value = $signed({~k[31], k[30:0]});
    endfunction

    always_comb begin
        k0 = make_key(reliable[0], accel[0]);
        k1 = make_key(reliable[1], accel[1]);
        k2 = make_key(reliable[2], accel[2]);
        k3 = make_key(reliable[3], accel[3]);

        // five compare-exchange elements in three levels
        a0 = (k0 <= k1) ? k0 : k1;
        a1 = (k0 <= k1) ? k1 : k0;
        a2 = (k2 <= k3) ? k2 : k3;
        a3 = (k2 <= k3) ? k3 : k2;
        b0 = (a0 <= a2) ? a0 : a2;
        b2 = (a0 <= a2) ? a2 : a0;
        b1 = (a1 <= a3) ? a1 : a3;
        b3 = (a1 <= a3) ? a3 : a1;
        c1 = (b1 <= b2) ? b1 : b2;
        c2 = (b1 <= b2) ? b2 : b1;

        s0 = key_value(b0);
        s1 = key_value(c1);
        s2 = key_value(c2);
        s3 = key_value(b3);
    end

    always_comb begin
        four  = (reliable == '1);
        q1x2  = {s0[31], s0} + {s1[31], s1};
        m12   = {s1[31], s1} + {s2[31], s2};
        s23   = {s2[31], s2} + {s3[31], s3};
        q3x2  = four ? s23 : m12;
        // sorted order keeps the doubled IQR non-negative
        iqr2  = {q3x2[32], q3x2} - {q1x2[32], q1x2};
        clip2 = {max_iqr, 1'b0};
        iqr_c = (iqr2 > $signed({2'b00, clip2})) ? clip2 : iqr2[31:0];
        off   = imuv_pkg::PROD_W'(iqr_scale) * imuv_pkg::PROD_W'(iqr_c);

        fence.active = ($countones(reliable) >= 3);
        fence.median = four ? m12[32:1] : s1;   // floor of the mean
        fence.upper  = ($signed(imuv_pkg::FENCE_W'(q3x2)) <<< 8)
                     + $signed(imuv_pkg::FENCE_W'(off));
        fence.lower  = ($signed(imuv_pkg::FENCE_W'(q1x2)) <<< 8)
                     - $signed(imuv_pkg::FENCE_W'(off));
    end

endmodule

// ===== design/imuv_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuv_tracker
// Fence compare per IMU, replacement by the median, outlier run counters,
// reliability flags and the sticky critical failure.
// ----------------------------------------------------------------------------
module imuv_tracker #(
    parameter int COUNT_WIDTH = imuv_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  imuv_pkg::accel_t                accel [imuv_pkg::NUM_IMUS],
    input  imuv_pkg::fence_t                fence,
    input  logic [imuv_pkg::LIMIT_W-1:0]    run_limit,
    output imuv_pkg::imu_mask_t             reliable,
    output imuv_pkg::accel_t                clean [imuv_pkg::NUM_IMUS],
    output imuv_pkg::status_t               status
);

    localparam int CMP_W = (COUNT_WIDTH > imuv_pkg::LIMIT_W) ? COUNT_WIDTH
                                                              : imuv_pkg::LIMIT_W;

    logic [COUNT_WIDTH-1:0]       run_cnt_reg  [imuv_pkg::NUM_IMUS];
    logic [COUNT_WIDTH-1:0]       run_cnt_next [imuv_pkg::NUM_IMUS];
    logic [COUNT_WIDTH-1:0]       run_cnt_inc  [imuv_pkg::NUM_IMUS];
    imuv_pkg::imu_mask_t          rel_flags_reg, rel_flags_next;
    logic [imuv_pkg::UCNT_W-1:0]  ucnt_reg, ucnt_next;
    logic [imuv_pkg::UCNT_W:0]    ucnt_sum;
    logic                         failure_reg, failure_next;
    imuv_pkg::imu_mask_t          outlier, drop;
    logic signed [imuv_pkg::FENCE_W-1:0] xs [imuv_pkg::NUM_IMUS];

    assign reliable = rel_flags_reg;

    always_comb begin
        for (int i = 0; i < imuv_pkg::NUM_IMUS; i++) begin
            xs[i]          = $signed(imuv_pkg::FENCE_W'(accel[i])) <<< 9;
            outlier[i]     = fence.active && rel_flags_reg[i]
                           && (xs[i] < fence.lower || xs[i] > fence.upper);
            run_cnt_inc[i] = (run_cnt_reg[i] == '1) ? run_cnt_reg[i]
                                                    : run_cnt_reg[i] + COUNT_WIDTH'(1);
            drop[i]        = outlier[i] && (CMP_W'(run_cnt_inc[i]) > CMP_W'(run_limit));
            // any reading that is not replaced clears its run
            run_cnt_next[i] = outlier[i] ? run_cnt_inc[i] : '0;
            clean[i]        = outlier[i] ? fence.median : accel[i];
        end

        ucnt_sum       = {1'b0, ucnt_reg} + (imuv_pkg::UCNT_W + 1)'($countones(drop));
        ucnt_next      = (ucnt_sum > {1'b0, imuv_pkg::UCNT_MAX}) ? imuv_pkg::UCNT_MAX
                                                                 : ucnt_sum[imuv_pkg::UCNT_W-1:0];
        rel_flags_next = rel_flags_reg & ~drop;
        failure_next   = failure_reg || !fence.active
                       || ((|outlier) && (ucnt_next > imuv_pkg::UCNT_W'(1)));

        status.outlier  = outlier;
        status.reliable = rel_flags_next;
        status.failure  = failure_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < imuv_pkg::NUM_IMUS; i++) begin
                run_cnt_reg[i] <= '0;
            end
            rel_flags_reg <= '1;
            ucnt_reg      <= '0;
            failure_reg   <= 1'b0;
        end else if (advance) begin
            for (int i = 0; i < imuv_pkg::NUM_IMUS; i++) begin
                run_cnt_reg[i] <= run_cnt_next[i];
            end
            rel_flags_reg <= rel_flags_next;
            ucnt_reg      <= ucnt_next;
            failure_reg   <= failure_next;
        end
    end

`ifndef SYNTHESIS
    a_rel_never_restored: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ((rel_flags_reg & ~$past(rel_flags_reg)) == '0))
        else $error("reliable flag set again after being cleared");

    a_failure_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        failure_reg |=> failure_reg)
        else $error("critical failure cleared");

    a_no_failure_three_left: assert property (@(posedge aclk) disable iff (!aresetn)
        !failure_reg |-> ($countones(rel_flags_reg) >= 3))
        else $error("fewer than three reliable IMUs without critical failure");
`endif

endmodule

// ===== design/imu_iqr_outlier_voter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_iqr_outlier_voter
// Tukey interquartile fence voter over four IMU acceleration readings.
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  input     s_accel_0..3                        s_valid / s_ready
//  result    m_clean_0..3, m_outlier_mask,       m_valid / m_ready
//            m_reliable_mask, m_critical_failure
//  config    cfg_index, cfg_wdata                cfg_we (no wait)
//
//  An accepted item moves from the input register to the result register;
//  one item per cycle sustained while m_ready stays high. The sort, fence
//  multiply and compare between the two registers set the cycle time.
//  Reset clears run counters, marks all IMUs reliable, loads register defaults.
//  A held result stalls the input register only once it is also full.
// ----------------------------------------------------------------------------
module imu_iqr_outlier_voter #(
    parameter int COUNT_WIDTH = imuv_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [imuv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imuv_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [imuv_pkg::ACCEL_W-1:0] s_accel_0,
    input  logic signed [imuv_pkg::ACCEL_W-1:0] s_accel_1,
    input  logic signed [imuv_pkg::ACCEL_W-1:0] s_accel_2,
    input  logic signed [imuv_pkg::ACCEL_W-1:0] s_accel_3,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [imuv_pkg::ACCEL_W-1:0] m_clean_0,
    output logic signed [imuv_pkg::ACCEL_W-1:0] m_clean_1,
    output logic signed [imuv_pkg::ACCEL_W-1:0] m_clean_2,
    output logic signed [imuv_pkg::ACCEL_W-1:0] m_clean_3,
    output logic [imuv_pkg::NUM_IMUS-1:0]       m_outlier_mask,
    output logic [imuv_pkg::NUM_IMUS-1:0]       m_reliable_mask,
    output logic                                m_critical_failure
);

    logic [imuv_pkg::SCALE_W-1:0]   iqr_scale_reg;
    logic [imuv_pkg::MAX_IQR_W-1:0] max_iqr_reg;
    logic [imuv_pkg::LIMIT_W-1:0]   run_limit_reg;

    logic                in_valid_reg;
    imuv_pkg::accel_t    in_accel_reg [imuv_pkg::NUM_IMUS];
    logic                out_valid_reg;
    imuv_pkg::accel_t    out_clean_reg [imuv_pkg::NUM_IMUS];
    imuv_pkg::status_t   out_status_reg;

    logic                in_xfer, out_free, advance;
    imuv_pkg::imu_mask_t reliable;
    imuv_pkg::fence_t    fence;
    imuv_pkg::accel_t    clean [imuv_pkg::NUM_IMUS];
    imuv_pkg::status_t   status;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_xfer  = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iqr_scale_reg <= imuv_pkg::IQR_SCALE_RST;
            max_iqr_reg   <= imuv_pkg::MAX_IQR_RST;
            run_limit_reg <= imuv_pkg::RUN_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                imuv_pkg::CFG_IQR_SCALE: begin
                    iqr_scale_reg <= cfg_wdata[imuv_pkg::SCALE_W-1:0];
                end
                imuv_pkg::CFG_MAX_IQR: begin
                    max_iqr_reg <= cfg_wdata[imuv_pkg::MAX_IQR_W-1:0];
                end
                imuv_pkg::CFG_RUN_LIMIT: begin
                    run_limit_reg <= cfg_wdata[imuv_pkg::LIMIT_W-1:0];
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_accel_reg[0] <= s_accel_0;
            in_accel_reg[1] <= s_accel_1;
            in_accel_reg[2] <= s_accel_2;
            in_accel_reg[3] <= s_accel_3;
        end
    end

    imuv_stats u_stats (
        .accel     (in_accel_reg),
        .reliable  (reliable),
        .iqr_scale (iqr_scale_reg),
        .max_iqr   (max_iqr_reg),
        .fence     (fence)
    );

    imuv_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .accel     (in_accel_reg),
        .fence     (fence),
        .run_limit (run_limit_reg),
        .reliable  (reliable),
        .clean     (clean),
        .status    (status)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < imuv_pkg::NUM_IMUS; i++) begin
                out_clean_reg[i] <= clean[i];
            end
            out_status_reg <= status;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_clean_0          = out_clean_reg[0];
    assign m_clean_1          = out_clean_reg[1];
    assign m_clean_2          = out_clean_reg[2];
    assign m_clean_3          = out_clean_reg[3];
    assign m_outlier_mask     = out_status_reg.outlier;
    assign m_reliable_mask    = out_status_reg.reliable;
    assign m_critical_failure = out_status_reg.failure;

`ifndef SYNTHESIS
    a_advance_fills_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register empty after a transfer from the input register");

    a_stalled_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled input item lost");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_status_reg)))
        else $error("stalled result changed before its transfer");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IMU interquartile outlier voter. Sends sample
// sets over the input channel and rebuilds every result in a bit-exact
// fence model that tracks run counters, reliable flags and the sticky
// failure. Runs directed corner sets, then random clusters with wild
// readings through the four-, three- and two-reliable regimes under
// several source and sink pacing profiles. Result transfers are compared
// field by field in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     SOAK_ITEMS   = 40;
    localparam logic [imuv_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam imuv_pkg::accel_t ACCEL_MAX = 32'sh7FFF_FFFF;
    localparam imuv_pkg::accel_t ACCEL_MIN = 32'sh8000_0000;
    localparam longint RUN_CNT_MAX  = (longint'(1) << imuv_pkg::COUNT_WIDTH_DEF) - 1;

    typedef logic [imuv_pkg::NUM_IMUS-1:0][imuv_pkg::ACCEL_W-1:0] sample_t;

    typedef struct packed {
        logic [imuv_pkg::NUM_IMUS-1:0][imuv_pkg::ACCEL_W-1:0] clean;
        imuv_pkg::imu_mask_t                                  outlier;
        imuv_pkg::imu_mask_t                                  reliable;
        logic                                                 failure;
    } vote_t;

    typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_we;
    logic [imuv_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [imuv_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    imuv_pkg::accel_t                s_accel_0, s_accel_1, s_accel_2, s_accel_3;
    logic                            m_valid;
    logic                            m_ready;
    imuv_pkg::accel_t                m_clean_0, m_clean_1, m_clean_2, m_clean_3;
    imuv_pkg::imu_mask_t             m_outlier_mask;
    imuv_pkg::imu_mask_t             m_reliable_mask;
    logic                            m_critical_failure;

    // fence model state
    longint              fence_scale;
    longint              iqr_clip;
    longint              run_limit;
    longint              run_cnt [imuv_pkg::NUM_IMUS];
    imuv_pkg::imu_mask_t rel_flags;
    int                  dropped_imus;
    logic                fail_flag;

    vote_t     pending_votes [$];
    int        mismatches;
    int        cycles;
    int        idle_pct;
    int        stall_pct;

    imu_iqr_outlier_voter #(
        .COUNT_WIDTH(imuv_pkg::COUNT_WIDTH_DEF)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_accel_0         (s_accel_0),
        .s_accel_1         (s_accel_1),
        .s_accel_2         (s_accel_2),
        .s_accel_3         (s_accel_3),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_clean_0         (m_clean_0),
        .m_clean_1         (m_clean_1),
        .m_clean_2         (m_clean_2),
        .m_clean_3         (m_clean_3),
        .m_outlier_mask    (m_outlier_mask),
        .m_reliable_mask   (m_reliable_mask),
        .m_critical_failure(m_critical_failure)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Exact fence vote; doubled sums and fences in units of 1/512 LSB.
    function automatic vote_t fence_vote(input sample_t smp);
        longint rd  [imuv_pkg::NUM_IMUS];
        longint srt [imuv_pkg::NUM_IMUS];
        longint v, q1x2, q3x2, mid, iqr2, off, upper, lower, xs;
        int     n, j;
        vote_t  r;
        n = 0;
        r = '0;
        for (int i = 0; i < imuv_pkg::NUM_IMUS; i++) begin
            rd[i] = $signed(smp[i]);
            r.clean[i] = smp[i];
            if (rel_flags[i]) begin
                srt[n] = rd[i];
                n++;
            end
        end
        if (n <= 2) begin
            for (int i = 0; i < imuv_pkg::NUM_IMUS; i++) run_cnt[i] = 0;
            fail_flag = 1'b1;
        end else begin
            for (int i = 1; i < n; i++) begin
                v = srt[i];
                j = i - 1;
                while (j >= 0 && srt[j] > v) begin
                    srt[j + 1] = srt[j];
                    j--;
                end
                srt[j + 1] = v;
            end
            q1x2 = srt[0] + srt[1];
            if (n == 4) begin
                q3x2 = srt[2] + srt[3];
                mid  = (srt[1] + srt[2]) >>> 1;   // floor toward minus infinity
            end else begin
                q3x2 = srt[1] + srt[2];
                mid  = srt[1];
            end
            iqr2 = q3x2 - q1x2;
            if (iqr2 > 2 * iqr_clip) iqr2 = 2 * iqr_clip;
            off   = fence_scale * iqr2;
            upper = q3x2 * 256 + off;
            lower = q1x2 * 256 - off;
            for (int i = 0; i < imuv_pkg::NUM_IMUS; i++) begin
                xs = rd[i] * 512;
                if (rel_flags[i] && (xs < lower || xs > upper)) begin
                    r.clean[i]   = mid[imuv_pkg::ACCEL_W-1:0];
                    r.outlier[i] = 1'b1;
                    if (run_cnt[i] < RUN_CNT_MAX) run_cnt[i]++;
                    if (run_cnt[i] > run_limit) begin
                        rel_flags[i] = 1'b0;
                        if (dropped_imus < imuv_pkg::UCNT_MAX) dropped_imus++;
                    end
                    if (dropped_imus > 1) fail_flag = 1'b1;
                end else begin
                    run_cnt[i] = 0;
                end
            end
        end
        r.reliable = rel_flags;
        r.failure  = fail_flag;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s at %0t: expected %0d, got %0d", field, $time, want, got);
    endtask

    task automatic check_vote();
        vote_t            want;
        imuv_pkg::accel_t got_clean [imuv_pkg::NUM_IMUS];
        if (pending_votes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result transfer with nothing pending at %0t", $time);
        end else begin
            got_clean = '{m_clean_0, m_clean_1, m_clean_2, m_clean_3};
            want = pending_votes.pop_front();
            for (int i = 0; i < imuv_pkg::NUM_IMUS; i++)
                if (got_clean[i] !== want.clean[i])
                    flag_mismatch($sformatf("clean_%0d", i), $signed(want.clean[i]),
                                  got_clean[i]);
            if (m_outlier_mask !== want.outlier)
                flag_mismatch("outlier_mask", want.outlier, m_outlier_mask);
            if (m_reliable_mask !== want.reliable)
                flag_mismatch("reliable_mask", want.reliable, m_reliable_mask);
            if (m_critical_failure !== want.failure)
                flag_mismatch("critical_failure", want.failure, m_critical_failure);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) check_vote();
    end

    task automatic set_pace(input pace_t mode);
        case (mode)
            PACE_FULL:       begin idle_pct = 0;  stall_pct = 0;  end
            PACE_SRC_IDLE:   begin idle_pct = 82; stall_pct = 0;  end
            PACE_SINK_STALL: begin idle_pct = 0;  stall_pct = 82; end
            default:         begin idle_pct = 17; stall_pct = 17; end
        endcase
    endtask

    task automatic send_sample(input imuv_pkg::accel_t a0, input imuv_pkg::accel_t a1,
                               input imuv_pkg::accel_t a2, input imuv_pkg::accel_t a3);
        sample_t smp;
        vote_t   want;
        smp = {a3, a2, a1, a0};
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid   <= 1'b1;
        s_accel_0 <= a0;
        s_accel_1 <= a1;
        s_accel_2 <= a2;
        s_accel_3 <= a3;
        do @(posedge aclk); while (s_ready !== 1'b1);
        want = fence_vote(smp);
        pending_votes = {pending_votes, want};
    endtask

    // Tight cluster around a random base, up to max_wild thrown off; or all four random.
    function automatic sample_t random_sample(input int max_wild);
        sample_t     smp;
        logic [31:0] base, spread, off;
        int          wild, idx;
        if ($urandom_range(7) == 0) begin
            for (int i = 0; i < imuv_pkg::NUM_IMUS; i++) smp[i] = $urandom();
        end else begin
            base   = $urandom();
            spread = 32'd1 << $urandom_range(20);
            for (int i = 0; i < imuv_pkg::NUM_IMUS; i++) smp[i] = base + $urandom_range(spread);
            wild = $urandom_range(max_wild);
            for (int k = 0; k < wild; k++) begin
                off = spread * $urandom_range(12, 1);
                idx = $urandom_range(imuv_pkg::NUM_IMUS - 1);
                smp[idx] = $urandom_range(1) ? base + off : base - off;
            end
        end
        return smp;
    endfunction

    task automatic send_random(input int count, input int max_wild);
        sample_t smp;
        for (int k = 0; k < count; k++) begin
            smp = random_sample(max_wild);
            send_sample(smp[0], smp[1], smp[2], smp[3]);
        end
    endtask

    // IMUs 0..2 on one value, IMU 3 thrown off above or below it
    task automatic send_imu3_wild();
        logic [31:0] base, off;
        base = $urandom();
        off  = 32'd1 << $urandom_range(20);
        send_sample(base, base, base, $urandom_range(1) ? base + off : base - off);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_votes.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [imuv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data[imuv_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            imuv_pkg::CFG_IQR_SCALE: fence_scale = longint'(data[imuv_pkg::SCALE_W-1:0]);
            imuv_pkg::CFG_MAX_IQR:   iqr_clip    = longint'(data[imuv_pkg::MAX_IQR_W-1:0]);
            imuv_pkg::CFG_RUN_LIMIT: run_limit   = longint'(data[imuv_pkg::LIMIT_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic randomize_fences();
        write_reg(imuv_pkg::CFG_IQR_SCALE, $urandom_range(768));
        write_reg(imuv_pkg::CFG_MAX_IQR, $urandom_range(31'h7FFF_FFFF) >> $urandom_range(30));
    endtask

    task automatic test_default_fences();
        set_pace(PACE_FULL);
        send_sample(0, 0, 0, 0);
        send_sample(ACCEL_MAX, ACCEL_MAX, ACCEL_MAX, ACCEL_MAX);
        send_sample(ACCEL_MIN, ACCEL_MIN, ACCEL_MIN, ACCEL_MIN);
        send_sample(ACCEL_MIN, ACCEL_MAX, ACCEL_MIN, ACCEL_MAX);
        send_sample(-3, -2, 1, 4);      // odd negative middle sum
        send_sample(0, 1, 2, 3);
        // one wild reading per IMU, IQR hits the clip
        send_sample(2621440, 0, 1, 2);
        send_sample(0, -2621440, 1, 2);
        send_sample(0, 1, 2621440, 2);
        send_sample(0, 1, 2, ACCEL_MAX);
    endtask

    task automatic test_fence_registers();
        write_reg(imuv_pkg::CFG_IQR_SCALE, 0);
        send_random(3, 2);
        write_reg(imuv_pkg::CFG_MAX_IQR, 0);
        send_random(3, 2);
        write_reg(imuv_pkg::CFG_IQR_SCALE, {16'h5A5A, 16'hFFFF});   // upper bits dropped
        send_random(3, 2);
        write_reg(imuv_pkg::CFG_MAX_IQR, 32'h7FFF_FFFF);
        send_random(3, 2);
        // unmapped index leaves every register alone
        write_reg(CFG_UNMAPPED, $urandom());
        send_random(3, 2);
    endtask

    task automatic test_four_reliable_random();
        for (int m = PACE_FULL; m <= PACE_BOTH; m++) begin
            set_pace(pace_t'(m));
            randomize_fences();
            write_reg(imuv_pkg::CFG_RUN_LIMIT, {16'h2AAA, 16'($urandom_range(65534, 1000))});
            send_random(300, 2);
        end
    endtask

    task automatic test_run_limit_top();
        int guard;
        set_pace(PACE_FULL);
        write_reg(imuv_pkg::CFG_IQR_SCALE, 0);
        write_reg(imuv_pkg::CFG_RUN_LIMIT, 65534);
        // hold IMU 3 off the cluster; the high limit keeps it reliable
        repeat (SOAK_ITEMS) send_imu3_wild();
        // lower the limit under the run so the next outlier drops IMU 3
        write_reg(imuv_pkg::CFG_RUN_LIMIT, SOAK_ITEMS / 2);
        guard = 0;
        while (rel_flags[3] && guard < SOAK_ITEMS) begin
            send_imu3_wild();
            guard++;
        end
    endtask

    task automatic test_three_reliable();
        set_pace(PACE_FULL);
        write_reg(imuv_pkg::CFG_IQR_SCALE, 32'(imuv_pkg::IQR_SCALE_RST));
        write_reg(imuv_pkg::CFG_MAX_IQR, 32'(imuv_pkg::MAX_IQR_RST));
        send_sample(0, 0, 0, ACCEL_MAX);
        send_sample(ACCEL_MIN, ACCEL_MAX, 0, ACCEL_MIN);
        send_sample(2621440, 0, 1, 5);
        send_sample(-3, -2, 7, 0);
        for (int m = PACE_FULL; m <= PACE_BOTH; m++) begin
            set_pace(pace_t'(m));
            randomize_fences();
            send_random(100, 1);
        end
    endtask

    task automatic test_double_drop();
        set_pace(PACE_FULL);
        write_reg(imuv_pkg::CFG_IQR_SCALE, 0);
        write_reg(imuv_pkg::CFG_RUN_LIMIT, 0);
        // lowest and highest reliable readings both fenced out in one set
        send_sample(-5, 0, 7, 123);
        send_sample(1, 2, 3, 4);
    endtask

    task automatic test_pass_through();
        send_sample(ACCEL_MAX, ACCEL_MIN, 0, -1);
        for (int m = PACE_FULL; m <= PACE_BOTH; m++) begin
            set_pace(pace_t'(m));
            randomize_fences();
            write_reg(imuv_pkg::CFG_RUN_LIMIT, $urandom_range(65534));
            send_random(60, 2);
        end
    endtask

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_accel_0    = '0;
        s_accel_1    = '0;
        s_accel_2    = '0;
        s_accel_3    = '0;
        m_ready      = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        mismatches   = 0;
        cycles       = 0;
        fence_scale  = longint'(imuv_pkg::IQR_SCALE_RST);
        iqr_clip     = longint'(imuv_pkg::MAX_IQR_RST);
        run_limit    = longint'(imuv_pkg::RUN_LIMIT_RST);
        for (int i = 0; i < imuv_pkg::NUM_IMUS; i++) run_cnt[i] = 0;
        rel_flags    = '1;
        dropped_imus = 0;
        fail_flag    = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_fences();
        test_fence_registers();
        test_four_reliable_random();
        test_run_limit_top();
        test_three_reliable();
        test_double_drop();
        test_pass_through();

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_votes.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/imuv_pkg.sv
design/imuv_stats.sv
design/imuv_tracker.sv
design/imu_iqr_outlier_voter.sv
sim/tb.sv
